@@ hdl/m64dec_pkg.sv @@
// m64dec_pkg: shared types, codes and decode tables for the MIPS64 decoder.
// Depends on nothing; used by the decode core, the top level and the checker.
package m64dec_pkg;

	// Major opcodes that open a secondary decode table
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;

	// Opcode groups
	localparam logic [1:0] GRP_SPECIAL = 2'd0;
	localparam logic [1:0] GRP_REGIMM  = 2'd1;
	localparam logic [1:0] GRP_PRIMARY = 2'd2;

	// Operand layout classes
	localparam logic [3:0] FMT_NONE     = 4'd0;
	localparam logic [3:0] FMT_SHIFT_SA = 4'd1;
	localparam logic [3:0] FMT_SHIFT_V  = 4'd2;
	localparam logic [3:0] FMT_RRR      = 4'd3;
	localparam logic [3:0] FMT_RS       = 4'd4;
	localparam logic [3:0] FMT_RD       = 4'd5;
	localparam logic [3:0] FMT_RD_RS    = 4'd6;
	localparam logic [3:0] FMT_RS_RT    = 4'd7;
	localparam logic [3:0] FMT_BREAK    = 4'd8;
	localparam logic [3:0] FMT_BR_RS    = 4'd9;
	localparam logic [3:0] FMT_BR_RS_RT = 4'd10;
	localparam logic [3:0] FMT_TRAP_IMM = 4'd11;
	localparam logic [3:0] FMT_ALU_IMM  = 4'd12;
	localparam logic [3:0] FMT_LUI      = 4'd13;
	localparam logic [3:0] FMT_MEM      = 4'd14;
	localparam logic [3:0] FMT_JUMP     = 4'd15;

	localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;
	localparam logic [31:0] PC_STEP          = 32'd4;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] instr_word;
	} cmd_t;

	typedef struct packed {
		logic        valid_res;
		logic [1:0]  op_group;
		logic [5:0]  op_code;
		logic [3:0]  operand_format;
		logic [4:0]  reg_s;
		logic [4:0]  reg_t;
		logic [4:0]  reg_d;
		logic [4:0]  shift_amount;
		logic [15:0] imm_field;
		logic [19:0] break_code;
		logic [31:0] target_addr;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] fmt;
	} fmt_entry_t;

	function automatic fmt_entry_t fmt_ok(input logic [3:0] f);
		fmt_entry_t e;
		e.ok  = 1'b1;
		e.fmt = f;
		return e;
	endfunction

	localparam fmt_entry_t FMT_BAD = '{ok: 1'b0, fmt: FMT_NONE};

	// SPECIAL function table
	function automatic fmt_entry_t special_fmt(input logic [5:0] fn);
		fmt_entry_t e;
		e = FMT_BAD;
		unique case (fn)
			6'd0, 6'd2, 6'd3, 6'd56, 6'd58, 6'd59, 6'd60, 6'd62, 6'd63:
				e = fmt_ok(FMT_SHIFT_SA);
			6'd4, 6'd6, 6'd7, 6'd20, 6'd22, 6'd23:
				e = fmt_ok(FMT_SHIFT_V);
			6'd8, 6'd17, 6'd19:
				e = fmt_ok(FMT_RS);
			6'd9:
				e = fmt_ok(FMT_RD_RS);
			6'd12, 6'd15:
				e = fmt_ok(FMT_NONE);
			6'd13:
				e = fmt_ok(FMT_BREAK);
			6'd16, 6'd18:
				e = fmt_ok(FMT_RD);
			6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
			6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd54:
				e = fmt_ok(FMT_RS_RT);
			6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
			6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47:
				e = fmt_ok(FMT_RRR);
			default:
				e = FMT_BAD;
		endcase
		return e;
	endfunction

	// REGIMM rt-code table
	function automatic fmt_entry_t regimm_fmt(input logic [4:0] rt);
		fmt_entry_t e;
		e = FMT_BAD;
		unique case (rt)
			5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd18, 5'd19:
				e = fmt_ok(FMT_BR_RS);
			5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14:
				e = fmt_ok(FMT_TRAP_IMM);
			default:
				e = FMT_BAD;
		endcase
		return e;
	endfunction

	// Primary opcode table
	function automatic fmt_entry_t primary_fmt(input logic [5:0] op);
		fmt_entry_t e;
		e = FMT_BAD;
		unique case (op)
			6'd2, 6'd3:
				e = fmt_ok(FMT_JUMP);
			6'd4, 6'd5, 6'd20, 6'd21:
				e = fmt_ok(FMT_BR_RS_RT);
			6'd6, 6'd7, 6'd22, 6'd23:
				e = fmt_ok(FMT_BR_RS);
			6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd24, 6'd25:
				e = fmt_ok(FMT_ALU_IMM);
			6'd15:
				e = fmt_ok(FMT_LUI);
			6'd26, 6'd27, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
			6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47,
			6'd48, 6'd52, 6'd55, 6'd56, 6'd60, 6'd63:
				e = fmt_ok(FMT_MEM);
			default:
				e = FMT_BAD;
		endcase
		return e;
	endfunction

endpackage

@@ hdl/m64dec_core.sv @@
// m64dec_core: combinational decode of one instruction word and its address.
// Depends on m64dec_pkg for the word types, codes and format tables.
module m64dec_core (
	input  m64dec_pkg::cmd_t cmd,
	output m64dec_pkg::res_t result
);

	logic [31:0]            w;
	logic [5:0]             major;
	logic [1:0]             group;
	logic [5:0]             code;
	m64dec_pkg::fmt_entry_t ent;
	logic [31:0]            br_off;
	logic [31:0]            target;

	assign w     = cmd.instr_word;
	assign major = w[31:26];

	always_comb begin
		priority if (major == m64dec_pkg::OP_SPECIAL) begin
			group = m64dec_pkg::GRP_SPECIAL;
			code  = w[5:0];
			ent   = m64dec_pkg::special_fmt(w[5:0]);
		end else if (major == m64dec_pkg::OP_REGIMM) begin
			group = m64dec_pkg::GRP_REGIMM;
			code  = {1'b0, w[20:16]};
			ent   = m64dec_pkg::regimm_fmt(w[20:16]);
		end else begin
			group = m64dec_pkg::GRP_PRIMARY;
			code  = major;
			ent   = m64dec_pkg::primary_fmt(major);
		end
	end

	// sign-extended word offset, scaled to bytes
	assign br_off = {{14{w[15]}}, w[15:0], 2'b00};

	always_comb begin
		target = '0;
		if (ent.ok) begin
			if (ent.fmt == m64dec_pkg::FMT_BR_RS || ent.fmt == m64dec_pkg::FMT_BR_RS_RT) begin
				target = cmd.pc + m64dec_pkg::PC_STEP + br_off;
			end else if (ent.fmt == m64dec_pkg::FMT_JUMP) begin
				target = (cmd.pc & m64dec_pkg::JUMP_REGION_MASK) | {4'b0, w[25:0], 2'b00};
			end
		end
	end

	always_comb begin
		result.valid_res      = ent.ok;
		result.op_group       = group;
		result.op_code        = code;
		result.operand_format = ent.ok ? ent.fmt : m64dec_pkg::FMT_NONE;
		result.reg_s          = w[25:21];
		result.reg_t          = w[20:16];
		result.reg_d          = w[15:11];
		result.shift_amount   = w[10:6];
		result.imm_field      = w[15:0];
		result.break_code     = w[25:6];
		result.target_addr    = target;
	end

endmodule

@@ hdl/mips64_instruction_decoder.sv @@
// mips64_instruction_decoder: top level, input register, decode core, result register.
// Depends on m64dec_pkg and m64dec_core.
//
//  channel   | signals                  | direction | handshake
//  ----------+--------------------------+-----------+---------------------------------
//  command   | start, busy, cmd         | in        | word taken when start & !busy
//  result    | done, result             | out       | word shown for one cycle on done
//
// An accepted word is captured in the input register, decoded, and captured in the result register, which drives done.
// One word is taken every cycle; the rate is set by the single decode stage
// between the input register and the result register.
// busy stays low: the pipeline has no stall path, and the receiver cannot hold
// results off, so each word simply advances one stage per clock.
// arst_n clears the stage valid flags; payload registers are not reset.
module mips64_instruction_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  m64dec_pkg::cmd_t cmd,
	output logic             done,
	output m64dec_pkg::res_t result
);

	logic             vld_s1;
	m64dec_pkg::cmd_t cmd_s1;
	logic             vld_s2;
	m64dec_pkg::res_t res_s2;
	m64dec_pkg::res_t dec_res;
	logic             take;

	// never stalls: every start is accepted
	assign busy = 1'b0;
	assign take = start & ~busy;

	// stage 1: capture the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	// decode between the two registers
	m64dec_core u_core (
		.cmd    (cmd_s1),
		.result (dec_res)
	);

	// stage 2: hold the decoded word for exactly one cycle of done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule

@@ hdl/m64dec_checker.sv @@
// m64dec_checker: port-level assertions for the MIPS64 decoder, bound to the top.
// Depends on m64dec_pkg and mips64_instruction_decoder.
module m64dec_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input m64dec_pkg::cmd_t cmd,
	input logic             done,
	input m64dec_pkg::res_t result
);

	// every accepted word is followed by done
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted word produced no result");

	// no result without an earlier accepted word
	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted word");

	// raw fields follow the accepted word that produced the result
	a_fields_track: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 (result.reg_s == $past(cmd.instr_word[25:21], 2)
			&& result.imm_field == $past(cmd.instr_word[15:0], 2)))
		else $error("raw fields do not match accepted word");

	// invalid words carry no format and no target
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.valid_res) |->
			(result.operand_format == m64dec_pkg::FMT_NONE && result.target_addr == '0))
		else $error("invalid word with format or target");

endmodule

bind mips64_instruction_decoder m64dec_checker u_m64dec_checker (.*);
